[hdl/deq_pkg.sv]
// package for the deque engine: operation and status codes,
// and the control word shared by the chain of storage cells
// no dependencies
`default_nettype none

package deq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_WRITE      = 3'd5;
    localparam logic [2:0] OP_SEARCH     = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // one control word drives every cell of the row
    typedef struct packed {
        logic shift_fwd;   // each cell takes its back neighbor, ring wraps
        logic shift_back;  // each cell takes its front neighbor, cell 0 takes the value
        logic wr_req;      // the cell at the write index takes the value
    } t_chain_ctl;

endpackage

`default_nettype wire

[hdl/deq_cell.sv]
// one storage cell of the deque row: holds one entry
// depends on deq_pkg for the chain control word
`default_nettype none

module deq_cell #(
    parameter int DATA_BITS = 32,
    parameter int IW        = 8,
    parameter int IDX       = 0
) (
    input  wire                           i_clk,
    input  wire deq_pkg::t_chain_ctl      i_ctl,
    input  wire        [IW-1:0]           i_wr_pos,
    input  wire signed [DATA_BITS-1:0]    i_wr_data,
    input  wire signed [DATA_BITS-1:0]    i_prev,
    input  wire signed [DATA_BITS-1:0]    i_next,
    output logic signed [DATA_BITS-1:0]   o_data
);

    logic signed [DATA_BITS-1:0] r_data;
    logic signed [DATA_BITS-1:0] n_data;
    logic                        wr_hit;

    assign wr_hit = i_ctl.wr_req && (i_wr_pos == IW'(IDX));

    always_comb begin
        n_data = r_data;
        priority if (wr_hit) begin
            n_data = i_wr_data;
        end else if (i_ctl.shift_back) begin
            n_data = i_prev;
        end else if (i_ctl.shift_fwd) begin
            n_data = i_next;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[hdl/double_ended_queue_engine.sv]
// deque engine top level: control sequencer over a row of deq_cell entries
// depends on deq_pkg and deq_cell
// push, pop, overwrite, bad position, unused code, empty search: result registered
// in the cycle after accept, busy stays low, one item per cycle
// read and search: result set by one full turn of the ring past cell 0, where entries are
// compared and captured; busy is high and start is ignored until the turn is done
// reset (synchronous, active low) empties the deque; cell contents stay undefined
`default_nettype none

module double_ended_queue_engine #(
    parameter int CAPACITY  = 256,
    parameter int DATA_BITS = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire        [2:0]  i_func,
    input  wire        [7:0]  i_position,
    input  wire signed [31:0] i_value,
    output logic              o_done,
    output logic signed [31:0] o_read_value,
    output logic              o_found,
    output logic       [7:0]  o_found_position,
    output logic       [1:0]  o_status,
    output logic       [8:0]  o_entry_count
);

    import deq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_ROT  = 1'b1;

    logic signed [DATA_BITS-1:0] cell_data [CAPACITY];
    logic signed [DATA_BITS-1:0] wval;
    t_chain_ctl                  ctl;
    logic        [IW-1:0]        wr_pos;

    logic                        r_state, n_state;
    logic        [CW-1:0]        r_count, n_count;
    logic        [CW-1:0]        r_step, n_step;
    logic                        r_search, n_search;
    logic        [PW-1:0]        r_pos, n_pos;
    logic signed [DATA_BITS-1:0] r_val, n_val;
    logic signed [DATA_BITS-1:0] r_rd, n_rd;
    logic                        r_hit, n_hit;
    logic        [CW-1:0]        r_hit_pos, n_hit_pos;

    logic                        r_done, n_done;
    logic signed [31:0]          r_out_rd, n_out_rd;
    logic                        r_out_found, n_out_found;
    logic        [7:0]           r_out_fpos, n_out_fpos;
    logic        [1:0]           r_out_status, n_out_status;

    logic                        full;
    logic                        empty;
    logic                        pos_bad;
    logic                        rd_match;
    logic                        srch_match;

    assign wval = DATA_BITS'(i_value);

    // ring of cells, front entry sits in cell 0 while idle
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_BITS-1:0] prev_d;
        logic signed [DATA_BITS-1:0] next_d;
        if (g == 0) begin : g_first
            assign prev_d = wval;
        end else begin : g_mid
            assign prev_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_d = cell_data[0];
        end else begin : g_inner
            assign next_d = cell_data[g+1];
        end
        deq_cell #(
            .DATA_BITS (DATA_BITS),
            .IW        (IW),
            .IDX       (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_wr_pos  (wr_pos),
            .i_wr_data (wval),
            .i_prev    (prev_d),
            .i_next    (next_d),
            .o_data    (cell_data[g])
        );
    end

    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign pos_bad = (PW'(i_position) >= PW'(r_count));

    // while the ring turns, cell 0 holds the entry at position r_step
    assign rd_match   = !r_search && (PW'(r_step) == r_pos);
    assign srch_match = r_search && !r_hit && (r_step < r_count) && (cell_data[0] == r_val);

    always_comb begin
        ctl          = '0;
        wr_pos       = IW'(i_position);
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_search     = r_search;
        n_pos        = r_pos;
        n_val        = r_val;
        n_rd         = r_rd;
        n_hit        = r_hit;
        n_hit_pos    = r_hit_pos;
        n_done       = 1'b0;
        n_out_rd     = r_out_rd;
        n_out_found  = r_out_found;
        n_out_fpos   = r_out_fpos;
        n_out_status = r_out_status;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_done       = 1'b1;
                    n_out_rd     = '0;
                    n_out_found  = 1'b0;
                    n_out_fpos   = '0;
                    n_out_status = ST_OK;
                    unique case (i_func)
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                ctl.shift_back = 1'b1;
                                n_count        = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                ctl.wr_req = 1'b1;
                                wr_pos     = r_count[IW-1:0];
                                n_count    = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                ctl.shift_fwd = 1'b1;
                                n_count       = r_count - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (pos_bad) begin
                                n_out_status = ST_RANGE;
                            end else begin
                                n_done   = 1'b0;
                                n_state  = S_ROT;
                                n_search = 1'b0;
                                n_pos    = PW'(i_position);
                                n_step   = '0;
                                n_rd     = '0;
                                n_hit    = 1'b0;
                            end
                        end
                        OP_WRITE: begin
                            if (pos_bad) begin
                                n_out_status = ST_RANGE;
                            end else begin
                                ctl.wr_req = 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            // nothing held: immediate miss
                            if (!empty) begin
                                n_done    = 1'b0;
                                n_state   = S_ROT;
                                n_search  = 1'b1;
                                n_val     = wval;
                                n_step    = '0;
                                n_rd      = '0;
                                n_hit     = 1'b0;
                                n_hit_pos = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ROT: begin
                ctl.shift_fwd = 1'b1;
                n_step        = r_step + 1'b1;
                if (rd_match) begin
                    n_rd = cell_data[0];
                end
                if (srch_match) begin
                    n_hit     = 1'b1;
                    n_hit_pos = r_step;
                end
                // full turn done, ring back in order
                if (r_step == CW'(CAPACITY - 1)) begin
                    n_state      = S_IDLE;
                    n_done       = 1'b1;
                    n_out_rd     = 32'(n_rd);
                    n_out_found  = n_hit;
                    n_out_fpos   = n_hit ? 8'(n_hit_pos) : 8'd0;
                    n_out_status = ST_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_step       <= n_step;
        r_search     <= n_search;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_rd         <= n_rd;
        r_hit        <= n_hit;
        r_hit_pos    <= n_hit_pos;
        r_out_rd     <= n_out_rd;
        r_out_found  <= n_out_found;
        r_out_fpos   <= n_out_fpos;
        r_out_status <= n_out_status;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_read_value     = r_out_rd;
    assign o_found          = r_out_found;
    assign o_found_position = r_out_fpos;
    assign o_status         = r_out_status;
    assign o_entry_count    = 9'(r_count);

endmodule

`default_nettype wire

[hdl/deq_checker.sv]
// port-level checker for the deque engine, bound to the top level
// depends on deq_pkg for operation and status codes
`default_nettype none

module deq_checker #(
    parameter int CAPACITY = 256
) (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire [2:0] i_func,
    input wire       o_done,
    input wire       o_found,
    input wire [1:0] o_status,
    input wire [8:0] o_entry_count
);

    import deq_pkg::*;

    // single-step operations report in the very next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func != OP_READ && i_func != OP_SEARCH) |=> o_done)
        else $error("single-step item gave no result in the next cycle");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_entry_count == 9'(CAPACITY)))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (o_entry_count == 9'd0))
        else $error("empty status with entries held");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_status == ST_OK))
        else $error("search hit with error status");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && !busy))
        else $error("result or busy right after reset");

endmodule

bind double_ended_queue_engine deq_checker #(
    .CAPACITY (CAPACITY)
) u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_func        (i_func),
    .o_done        (o_done),
    .o_found       (o_found),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);

`default_nettype wire
